>>> src/stsg_pkg.sv
// Package for the sine table sample generator.
// Holds widths, status codes, the CORDIC gain and the arctangent table.
package stsg_pkg;
  localparam int IndexW = 12;
  localparam int CodeW = 12;
  localparam int StatW = 2;
  localparam int CfgW = 16;
  localparam int ZW = 33;
  localparam int XW = 18;
  localparam int AtanEntries = 24;
  localparam int DefTableDepth = 4096;
  localparam int DefPhaseBits = 16;
  localparam int DefCordicStages = 16;
  localparam logic [XW-1:0] GainQ15 = 18'd19898;
  localparam logic [CfgW-1:0] PeakReset = 16'd4095;
  localparam logic [CfgW-1:0] PeriodReset = 16'd4096;
  localparam logic [StatW-1:0] StOk = 2'd0;
  localparam logic [StatW-1:0] StBadCfg = 2'd1;
  localparam logic [StatW-1:0] StBadIdx = 2'd2;
  localparam logic RegPeak = 1'b0;
  localparam logic RegPeriod = 1'b1;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic [IndexW-1:0] idx;
    logic [StatW-1:0] status;
    logic [CfgW-2:0] half;
    logic [CfgW-1:0] period;
  } front_item_t;
endpackage

>>> src/stsg_stream_if.sv
// Valid/ready stream interface with a parameterized payload width.
// Depends on nothing.
interface stsg_stream_if #(parameter int W = 8) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/stsg_front.sv
// Front part: accepts an index, classifies it against the configuration.
// Depends on stsg_pkg.
module stsg_front #(
  parameter int TableDepth = stsg_pkg::DefTableDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [stsg_pkg::IndexW-1:0] in_idx,
  input  logic [stsg_pkg::CfgW-1:0] peak,
  input  logic [stsg_pkg::CfgW-1:0] period,
  output logic out_valid,
  input  logic out_ready,
  output stsg_pkg::front_item_t out_item
);
  import stsg_pkg::*;
  logic bad_cfg;
  logic [CfgW+1:0] lim;

  assign lim = ({2'b0, peak} + 18'd1) << 1;
  assign bad_cfg = (peak > 16'd4095) || (period == '0) || ({2'b0, period} > lim)
                   || ({16'b0, period} > 32'(TableDepth));
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_item.idx <= in_idx;
      out_item.half <= peak[CfgW-1:1];
      out_item.period <= period;
      if (bad_cfg) out_item.status <= StBadCfg;
      else if ({4'b0, in_idx} >= period) out_item.status <= StBadIdx;
      else out_item.status <= StOk;
    end
  end
endmodule

>>> src/stsg_fifo.sv
// Short queue between the front and back parts.
// Depends on stsg_pkg.
module stsg_fifo (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  stsg_pkg::front_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output stsg_pkg::front_item_t out_item
);
  import stsg_pkg::*;
  front_item_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic wr, rd;

  assign in_ready = cnt != 3'd4;
  assign out_valid = cnt != 3'd0;
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;
  assign out_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, wr} - {2'b0, rd};
    end
    if (wr) mem[wp] <= in_item;
  end
endmodule

>>> src/stsg_back.sv
// Back part: pipelined restoring divider, CORDIC stages and scaling.
// Depends on stsg_pkg.
module stsg_back #(
  parameter int PhaseBits = stsg_pkg::DefPhaseBits,
  parameter int CordicStages = stsg_pkg::DefCordicStages
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  stsg_pkg::front_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output logic [stsg_pkg::CodeW-1:0] out_code,
  output logic [stsg_pkg::StatW-1:0] out_status
);
  import stsg_pkg::*;
  localparam int NumW = IndexW + PhaseBits;
  localparam int RemW = CfgW + 1;
  localparam int Cs = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
  localparam int D = NumW + Cs + 3;

  logic adv;
  logic [D-1:0] v;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Divider: one quotient bit per stage.
  logic [NumW-1:0] dq [NumW+1];
  logic [RemW-1:0] dr [NumW+1];
  front_item_t di [NumW+1];

  always_comb begin
    dq[0] = {in_item.idx, {PhaseBits{1'b0}}};
    dr[0] = '0;
    di[0] = in_item;
  end

  for (genvar k = 0; k < NumW; k++) begin : g_div
    logic [RemW-1:0] t;
    logic [RemW-1:0] s;
    assign t = {dr[k][RemW-2:0], dq[k][NumW-1]};
    assign s = t - {1'b0, di[k].period};
    always_ff @(posedge clk) begin
      if (adv) begin
        di[k+1] <= di[k];
        if (!s[RemW-1]) begin
          dr[k+1] <= s;
          dq[k+1] <= {dq[k][NumW-2:0], 1'b1};
        end else begin
          dr[k+1] <= t;
          dq[k+1] <= {dq[k][NumW-2:0], 1'b0};
        end
      end
    end
  end

  // CORDIC.
  logic signed [XW-1:0] cx [Cs+1];
  logic signed [XW-1:0] cy [Cs+1];
  logic signed [ZW-1:0] cz [Cs+1];
  logic [1:0] cq [Cs+1];
  front_item_t ci [Cs+1];
  logic [31:0] ang;

  assign ang = 32'(dq[NumW][PhaseBits-1:0]) << (32 - PhaseBits);
  always_comb begin
    cx[0] = GainQ15;
    cy[0] = '0;
    cz[0] = {3'b0, ang[29:0]};
    cq[0] = ang[31:30];
    ci[0] = di[NumW];
  end

  for (genvar k = 0; k < Cs; k++) begin : g_cor
    localparam logic [ZW-1:0] At = {1'b0, atan_turns(k)};
    always_ff @(posedge clk) begin
      if (adv) begin
        ci[k+1] <= ci[k];
        cq[k+1] <= cq[k];
        if (!cz[k][ZW-1]) begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          cz[k+1] <= cz[k] - At;
        end else begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          cz[k+1] <= cz[k] + At;
        end
      end
    end
  end

  // Quadrant select, clamp and product.
  logic signed [XW:0] s_raw;
  logic signed [XW:0] s_cl;
  always_comb begin
    case (cq[Cs])
      2'd0: s_raw = {cy[Cs][XW-1], cy[Cs]};
      2'd1: s_raw = {cx[Cs][XW-1], cx[Cs]};
      2'd2: s_raw = -{cy[Cs][XW-1], cy[Cs]};
      default: s_raw = -{cx[Cs][XW-1], cx[Cs]};
    endcase
    if (s_raw > 19'sd32767) s_cl = 19'sd32767;
    else if (s_raw < -19'sd32768) s_cl = -19'sd32768;
    else s_cl = s_raw;
  end

  logic [15:0] m_off;
  front_item_t mi;
  front_item_t pi;
  logic [31:0] prod;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_off <= 16'(s_cl + 19'sd32768);
      mi <= ci[Cs];
      prod <= {17'b0, mi.half} * {16'b0, m_off};
      pi <= mi;
      out_status <= pi.status;
      if (pi.status != StOk) out_code <= '0;
      else if (prod[31:15] > 17'd4095) out_code <= 12'd4095;
      else out_code <= prod[26:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[D-2:0], in_valid};
  end
  assign out_valid = v[D-1];
endmodule

>>> src/sine_table_sample_generator_top.sv
// channel  dir  payload
// idx_in   in   sample_index[11:0]
// res_out  out  sample_code[11:0], status[1:0]
// One item per cycle while res_out is ready; a result passes, once its index is
// accepted, through the front register, a queue slot, 28 divider bit stages,
// 16 CORDIC stages and three output stages. Synchronous reset clears all
// valid flags. A stall on res_out freezes the back pipe; the queue and
// front keep taking items until the queue fills.
// Top level; depends on stsg_pkg, stsg_stream_if and the three parts.
module sine_table_sample_generator_top #(
  parameter int TableDepth = stsg_pkg::DefTableDepth,
  parameter int PhaseBits = stsg_pkg::DefPhaseBits,
  parameter int CordicStages = stsg_pkg::DefCordicStages
) (
  input logic clk,
  input logic rst,
  stsg_stream_if.sink idx_in,
  stsg_stream_if.source res_out,
  input logic cfg_we,
  input logic cfg_index,
  input logic [stsg_pkg::CfgW-1:0] cfg_data
);
  import stsg_pkg::*;
  logic [CfgW-1:0] peak, period;
  logic f_v, f_r, q_v, q_r;
  front_item_t f_item, q_item;
  logic [CodeW-1:0] code;
  logic [StatW-1:0] status;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= PeakReset;
      period <= PeriodReset;
    end else if (cfg_we) begin
      if (cfg_index == RegPeak) peak <= cfg_data;
      else period <= cfg_data;
    end
  end

  stsg_front #(.TableDepth(TableDepth)) u_front (
    .clk, .rst, .in_valid(idx_in.valid), .in_ready(idx_in.ready),
    .in_idx(idx_in.data[IndexW-1:0]), .peak, .period,
    .out_valid(f_v), .out_ready(f_r), .out_item(f_item));

  stsg_fifo u_fifo (
    .clk, .rst, .in_valid(f_v), .in_ready(f_r), .in_item(f_item),
    .out_valid(q_v), .out_ready(q_r), .out_item(q_item));

  stsg_back #(.PhaseBits(PhaseBits), .CordicStages(CordicStages)) u_back (
    .clk, .rst, .in_valid(q_v), .in_ready(q_r), .in_item(q_item),
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .out_code(code), .out_status(status));

  assign res_out.data = {code, status};

`ifndef SYNTHESIS
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && status != StOk |-> code == '0) else $error("code not zero");
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> status != 2'd3) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |=> res_out.valid) else $error("valid dropped");
`endif
endmodule

>>> verif/stsg_sample_checker.sv
// Checker for the sine table sample generator: watches the index and result
// channels, predicts each DAC code and compares. Depends on stsg_pkg.
module stsg_sample_checker
  import stsg_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic idx_valid,
  input logic idx_ready,
  input logic [IndexW-1:0] idx_data,
  input logic res_valid,
  input logic res_ready,
  input logic [CodeW+StatW-1:0] res_data,
  input logic cfg_we,
  input logic cfg_index,
  input logic [CfgW-1:0] cfg_data,
  output int fail_count,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [StatW-1:0] status;
  } sample_t;

  logic [CfgW-1:0] peak_reg;
  logic [CfgW-1:0] period_reg;
  sample_t expected_samples[$];

  function automatic logic signed [31:0] shift_floor(logic signed [31:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] sine_q15(logic [31:0] angle);
    logic [1:0] quad;
    longint z;
    logic signed [31:0] x, y, dx, dy, s;
    quad = angle[31:30];
    z = longint'({2'b00, angle[29:0]});
    x = 19898;
    y = 0;
    for (int i = 0; i < DefCordicStages && i < AtanEntries; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_turns(i));
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_turns(i));
      end
    end
    case (quad)
      2'd0: s = y;
      2'd1: s = x;
      2'd2: s = -y;
      default: s = -x;
    endcase
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s;
  endfunction

  function automatic sample_t predict_sample(logic [IndexW-1:0] idx);
    sample_t r;
    longint unsigned phase, half, code;
    logic [31:0] angle;
    logic signed [31:0] s;
    r.code = '0;
    if (peak_reg > 4095 || period_reg == 0 || 32'(period_reg) > (32'(peak_reg) + 1) * 2
        || period_reg > DefTableDepth) begin
      r.status = StBadCfg;
    end else if (idx >= period_reg) begin
      r.status = StBadIdx;
    end else begin
      r.status = StOk;
      phase = (longint'(idx) << DefPhaseBits) / longint'(period_reg);
      angle = 32'(phase << (32 - DefPhaseBits));
      s = sine_q15(angle);
      half = peak_reg >> 1;
      code = ((half * longint'(32768 + s)) & 64'hFFFF_FFFF) >> 15;
      if (code > 4095) code = 4095;
      r.code = code[CodeW-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = expected_samples.size();

  always @(posedge clk) begin
    sample_t got, want;
    if (rst) begin
      peak_reg <= PeakReset;
      period_reg <= PeriodReset;
      fail_count <= 0;
    end else begin
      if (idx_valid && idx_ready) expected_samples.push_back(predict_sample(idx_data));
      if (res_valid && res_ready) begin
        got = res_data;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected item", got, 0);
        end else begin
          want = expected_samples.pop_front();
          if (got.code !== want.code) report_mismatch("sample_code", got.code, want.code);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        end
      end
      if (cfg_we) begin
        if (cfg_index == RegPeak) peak_reg <= cfg_data;
        else period_reg <= cfg_data;
      end
    end
  end
endmodule

>>> verif/tb_sine_table_sample_generator_top.sv
// Testbench top for the sine table sample generator: drives indexes and
// configuration under random idling and gives the verdict from the checker.
// Depends on stsg_pkg, stsg_stream_if, the block and stsg_sample_checker.
module tb_sine_table_sample_generator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stsg_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = RegPeak;
  logic [CfgW-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  logic hold_off = 0;
  logic stall_mode = 0;

  stsg_stream_if #(.W(IndexW)) idx_ch(.clk(clk));
  stsg_stream_if #(.W(CodeW + StatW)) res_ch(.clk(clk));

  sine_table_sample_generator_top dut(
    .clk(clk), .rst(rst), .idx_in(idx_ch.sink), .res_out(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stsg_sample_checker checker_i(
    .clk(clk), .rst(rst),
    .idx_valid(idx_ch.valid), .idx_ready(idx_ch.ready), .idx_data(idx_ch.data),
    .res_valid(res_ch.valid), .res_ready(res_ch.ready), .res_data(res_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  initial begin
    idx_ch.valid = 0;
    idx_ch.data = '0;
    res_ch.ready = 0;
  end

  always @(negedge clk) begin
    if (hold_off) res_ch.ready <= 0;
    else if (stall_mode) res_ch.ready <= ($urandom_range(0, 3) != 0);
    else res_ch.ready <= 1;
  end

  task automatic write_reg(logic idx, logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_index(logic [IndexW-1:0] idx);
    idx_ch.valid <= 1;
    idx_ch.data <= idx;
    do @(posedge clk); while (!idx_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random(int count, int span);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++) begin
        if ($urandom_range(0, 7) == 0) send_index(IndexW'($urandom));
        else send_index(IndexW'($urandom_range(0, span)));
        left--;
      end
      if ($urandom_range(0, 2) == 0) begin
        idx_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    idx_ch.valid <= 0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_config(logic [CfgW-1:0] peak, logic [CfgW-1:0] period);
    write_reg(RegPeak, peak);
    write_reg(RegPeriod, period);
  endtask

  initial begin
    logic [CfgW-1:0] period;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_index(0);
    send_index(1024);
    send_index(2048);
    send_index(3072);
    send_index(4095);
    send_index(12'hAAA);
    send_index(12'h555);
    idx_ch.valid <= 0;
    drain();
    set_config(4095, 100);
    send_index(25); send_index(99); send_index(100); send_index(4095);
    idx_ch.valid <= 0;
    drain();
    set_config(4096, 100); send_index(5);
    idx_ch.valid <= 0; drain();
    set_config(16'hFFFF, 16'hFFFF); send_index(5);
    idx_ch.valid <= 0; drain();
    set_config(10, 0); send_index(0);
    idx_ch.valid <= 0; drain();
    set_config(10, 22); send_index(0); send_index(21);
    idx_ch.valid <= 0; drain();
    set_config(10, 23); send_index(0);
    idx_ch.valid <= 0; drain();
    set_config(4095, 4097); send_index(0);
    idx_ch.valid <= 0; drain();
    set_config(0, 2); send_index(0); send_index(1); send_index(2);
    idx_ch.valid <= 0; drain();
    set_config(1, 1); send_index(0);
    idx_ch.valid <= 0; drain();

    hold_off <= 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off <= 0;
      end
      begin
        set_config(4095, 4096);
        send_random(150, 4095);
      end
    join
    drain();

    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      stall_mode <= phase_no[0];
      if (phase_no == 7) begin
        set_config(CfgW'($urandom), CfgW'($urandom));
        period = 64;
      end else begin
        period = CfgW'($urandom_range(1, 4096));
        set_config(CfgW'($urandom_range(period / 2, 4095)), period);
      end
      send_random(110, (period > 4095) ? 4095 : period);
      drain();
    end

    if (fail_count == 0) $display("sine_table_sample_generator_top verification clean");
    else $display("sine_table_sample_generator_top verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("sine_table_sample_generator_top verification failed");
    $finish;
  end
endmodule
